// ----- sv/queue_load_balancer_core_assert.svh -----
// assertion macros used by the dispatcher top file
`ifndef QUEUE_LOAD_BALANCER_CORE_ASSERT_SVH
`define QUEUE_LOAD_BALANCER_CORE_ASSERT_SVH

// condition and consequence in the same cycle
`define QLB_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// consequence in the cycle after the condition
`define QLB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ----- sv/qlb_pkg.sv -----
package qlb_pkg;

  // field widths
  localparam int QIDX_W = 4;
  localparam int CNT_W  = 5;
  localparam int AMT_W  = 8;
  localparam int LEN_W  = 16;
  localparam int WORK_W = 24;
  localparam int JOB_W  = 32;

  // queues a 4-bit index can name
  localparam int QUEUE_LIMIT = 16;

  localparam logic [LEN_W-1:0]  LEN_MAX  = '1;
  localparam logic [WORK_W-1:0] WORK_MAX = '1;

  // dispatch policies
  localparam logic [1:0] POL_SHORTEST = 2'd0;
  localparam logic [1:0] POL_WORK     = 2'd1;
  localparam logic [1:0] POL_ROTATE   = 2'd2;
  localparam logic [1:0] POL_PAIR     = 2'd3;

  // item kinds
  localparam logic FUNC_DISPATCH = 1'b0;
  localparam logic FUNC_DEPART   = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // configuration register indexes
  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_ACTIVE = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan_init;
    logic scan_step;
    logic scan_first;
    logic commit;
  } qlb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic             depart;
    logic             bad;
    logic             pair;
    logic [CNT_W-1:0] count;
    logic             out_free;
  } qlb_stat_t;

endpackage

// ----- sv/queue_load_balancer_core.sv -----
// Job dispatcher for a bank of up to sixteen server queues, each with a job count and a
// pending-work total. A dispatch picks a queue by the policy register (shortest queue,
// least work, shortest from a random start, or two random choices) and adds the job;
// a departure removes one job from a named queue. Items are handled one at a time
// because every decision reads the counter bank through a single read port, one
// queue per cycle: a dispatch under the scanning policies reads every active queue,
// a two-choice dispatch reads its two picks, and a departure or a rejected dispatch
// skips the scan and goes straight to the commit step. The result sits
// in an output register, so the next item is taken while it waits; a result still
// waiting at the end of the next item's work holds that item back. Configuration
// writes are always accepted and act on the policy and queue count at once, so they
// belong between items, while no item is in progress.
`include "queue_load_balancer_core_assert.svh"

module queue_load_balancer_core
  import qlb_pkg::*;
#(
  parameter int NUM_QUEUES = 16
) (
  input  logic        clk,
  input  logic        rst,
  // input transaction
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // work_amount, queue_index, random_first, random_second
  input  logic        s_axis_tuser,  // func
  // result transaction
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,  // chosen_queue, length_before, work_before, job_number
  output logic [1:0]  m_axis_tuser,  // status
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data
);

  qlb_cmd_t  cmd;
  qlb_stat_t stat;

  assign cfg_ready = 1'b1;

  // sequencer
  qlb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // counters, scan and result
  qlb_dp #(
    .NUM_QUEUES (NUM_QUEUES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (s_axis_tdata),
    .in_user   (s_axis_tuser),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_user  (m_axis_tuser)
  );

  // checks
  `QLB_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `QLB_ASSERT_IMPL(a_commit_needs_room, cmd.commit, stat.out_free)
  `QLB_ASSERT_NEXT(a_result_after_commit, cmd.commit, m_axis_tvalid)
  `QLB_ASSERT_IMPL(a_range_zero, m_axis_tvalid && m_axis_tuser == ST_RANGE, m_axis_tdata[43:4] == '0)

endmodule

// ----- sv/qlb_ctrl.sv -----
module qlb_ctrl
  import qlb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  qlb_stat_t stat,
  output qlb_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_CHECK  = 4'b0010,
    S_SCAN   = 4'b0100,
    S_COMMIT = 4'b1000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] step, step_next;
  logic [CNT_W-1:0] limit;
  logic             last;

  // scan length: two picks or every active queue
  assign limit = stat.pair ? CNT_W'(2) : stat.count;
  assign last  = (step == limit - CNT_W'(1));

  assign in_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    step_next  = step;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.depart || stat.bad) begin
          state_next = S_COMMIT;
        end else begin
          cmd.scan_init = 1'b1;
          step_next     = '0;
          state_next    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step  = 1'b1;
        cmd.scan_first = (step == '0);
        if (last) begin
          state_next = S_COMMIT;
        end else begin
          step_next = step + CNT_W'(1);
        end
      end
      S_COMMIT: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

// ----- sv/qlb_dp.sv -----
module qlb_dp
  import qlb_pkg::*;
#(
  parameter int NUM_QUEUES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  qlb_cmd_t    cmd,
  output qlb_stat_t   stat,
  input  logic [23:0] in_data,
  input  logic        in_user,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [79:0] out_data,
  output logic [1:0]  out_user
);

  localparam int DEPTH = (NUM_QUEUES < QUEUE_LIMIT) ? NUM_QUEUES : QUEUE_LIMIT;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // configuration
  logic [1:0]       policy;
  logic [CNT_W-1:0] active;

  // latched item
  logic              func;
  logic [AMT_W-1:0]  amount;
  logic [QIDX_W-1:0] qidx;
  logic [QIDX_W-1:0] rnd1;
  logic [QIDX_W-1:0] rnd2;

  // per-queue counters
  logic [LEN_W-1:0]  qlen  [DEPTH];
  logic [WORK_W-1:0] qwork [DEPTH];
  logic [JOB_W-1:0]  jobs;

  // scan state
  logic [QIDX_W-1:0] addr;
  logic [QIDX_W-1:0] best;
  logic [WORK_W-1:0] best_key;

  // result register
  logic [QIDX_W-1:0] o_chosen;
  logic [LEN_W-1:0]  o_len;
  logic [WORK_W-1:0] o_work;
  logic [JOB_W-1:0]  o_job;
  logic [1:0]        o_status;

  logic [CNT_W-1:0]  n_raw, n_eff;
  logic              bad;
  logic [QIDX_W-1:0] sel;
  logic [IDX_W-1:0]  rd_idx;
  logic [LEN_W-1:0]  rd_len;
  logic [WORK_W-1:0] rd_work;
  logic [WORK_W-1:0] key_cur;
  logic              take;
  logic [CNT_W-1:0]  addr_p1;
  logic [QIDX_W-1:0] addr_adv;
  logic [WORK_W:0]   work_sum;

  logic              wr_en;
  logic [LEN_W-1:0]  wr_len;
  logic [WORK_W-1:0] wr_work;
  logic              job_inc;
  logic [QIDX_W-1:0] r_chosen;
  logic [LEN_W-1:0]  r_len;
  logic [WORK_W-1:0] r_work;
  logic [JOB_W-1:0]  r_job;
  logic [1:0]        r_status;

  // effective queue count
  assign n_raw = (active == '0) ? CNT_W'(1) : active;
  assign n_eff = (n_raw > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : n_raw;

  // range check of the indexes the item uses
  always_comb begin
    if (func == FUNC_DEPART) begin
      bad = ({1'b0, qidx} >= n_eff);
    end else begin
      bad = ((policy == POL_ROTATE) && ({1'b0, rnd1} >= n_eff)) ||
            ((policy == POL_PAIR) &&
             (({1'b0, rnd1} >= n_eff) || ({1'b0, rnd2} >= n_eff)));
    end
  end

  assign stat.depart   = (func == FUNC_DEPART);
  assign stat.bad      = bad;
  assign stat.pair     = (policy == POL_PAIR);
  assign stat.count    = n_eff;
  assign stat.out_free = !out_valid || out_ready;

  // single read port into the counter bank
  assign sel     = cmd.commit ? best : addr;
  assign rd_idx  = sel[IDX_W-1:0];
  assign rd_len  = qlen[rd_idx];
  assign rd_work = qwork[rd_idx];

  // compare key and scan decision
  assign key_cur = (policy == POL_WORK) ? rd_work : WORK_W'(rd_len);
  assign take    = cmd.scan_first ||
                   ((policy == POL_PAIR) ? (key_cur <= best_key) : (key_cur < best_key));

  // next scan address: the second pick under the two-choice policy, else circular over the active queues
  assign addr_p1  = {1'b0, addr} + CNT_W'(1);
  assign addr_adv = (policy == POL_PAIR) ? rnd2 :
                    ((addr_p1 == n_eff) ? '0 : addr_p1[QIDX_W-1:0]);

  assign work_sum = {1'b0, rd_work} + (WORK_W+1)'(amount);

  // result and write-back values
  always_comb begin
    wr_en    = 1'b0;
    wr_len   = rd_len;
    wr_work  = rd_work;
    job_inc  = 1'b0;
    r_chosen = '0;
    r_len    = '0;
    r_work   = '0;
    r_job    = '0;
    r_status = ST_OK;
    if (func == FUNC_DEPART) begin
      r_chosen = qidx;
      if (bad) begin
        r_status = ST_RANGE;
      end else begin
        r_len  = rd_len;
        r_work = rd_work;
        if (rd_len == '0) begin
          r_status = ST_EMPTY;
        end else begin
          wr_en   = 1'b1;
          wr_len  = rd_len - LEN_W'(1);
          wr_work = (rd_work > WORK_W'(amount)) ? rd_work - WORK_W'(amount) : '0;
        end
      end
    end else begin
      if (bad) begin
        r_status = ST_RANGE;
      end else begin
        r_chosen = best;
        r_len    = rd_len;
        r_work   = rd_work;
        r_job    = jobs;
        wr_en    = 1'b1;
        job_inc  = 1'b1;
        wr_len   = (rd_len == LEN_MAX) ? LEN_MAX : rd_len + LEN_W'(1);
        wr_work  = (work_sum > {1'b0, WORK_MAX}) ? WORK_MAX : work_sum[WORK_W-1:0];
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= POL_SHORTEST;
      active <= CNT_W'(16);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POLICY: policy <= cfg_data[1:0];
        REG_ACTIVE: active <= cfg_data;
        default:    policy <= policy;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func   <= in_user;
      amount <= in_data[7:0];
      qidx   <= in_data[11:8];
      rnd1   <= in_data[15:12];
      rnd2   <= in_data[19:16];
    end
  end

  // scan registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      best <= in_data[11:8];
    end else if (cmd.scan_step && take) begin
      best     <= addr;
      best_key <= key_cur;
    end
    if (cmd.scan_init) begin
      addr <= ((policy == POL_ROTATE) || (policy == POL_PAIR)) ? rnd1 : '0;
    end else if (cmd.scan_step) begin
      addr <= addr_adv;
    end
  end

  // counter bank and job number
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        qlen[i]  <= '0;
        qwork[i] <= '0;
      end
      jobs <= '0;
    end else if (cmd.commit) begin
      if (wr_en) begin
        qlen[rd_idx]  <= wr_len;
        qwork[rd_idx] <= wr_work;
      end
      if (job_inc) begin
        jobs <= jobs + JOB_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      o_chosen <= r_chosen;
      o_len    <= r_len;
      o_work   <= r_work;
      o_job    <= r_job;
      o_status <= r_status;
    end
  end

  assign out_data = {4'b0, o_job, o_work, o_len, o_chosen};
  assign out_user = o_status;

endmodule
